FILE: rtl/slt_pkg.sv
// Shared types, codes and default sizes for the sorted list table.
package slt_pkg;

  localparam int DEPTH_DEF   = 16;
  localparam int VALUE_W_DEF = 32;

  localparam int ACTION_W    = 2;
  localparam int IN_VALUE_W  = 32;
  localparam int POS_W       = 4;
  localparam int STATUS_W    = 2;
  localparam int OUT_VALUE_W = 32;
  localparam int OUT_COUNT_W = 5;
  localparam int S_TDATA_W   = 40;
  localparam int M_TDATA_W   = 40;

  // command queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;

  // input action codes
  localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_DELETE = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_GET    = 2'd2;

  // decoded operation codes
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;
  localparam logic [1:0] OP_GET    = 2'd2;
  localparam logic [1:0] OP_NOP    = 2'd3;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BADPOS = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd3;

  typedef struct packed {
    logic [1:0]            op;
    logic [IN_VALUE_W-1:0] value;
    logic [POS_W-1:0]      position;
  } item_t;

endpackage

FILE: rtl/sorted_list_table_core.sv
// Sorted list table: insert, delete-at and get-at on an ascending shift table.
// An accepted input beat is held in the command queue, then executed by the back end
// into its result register, which drives the output beat.
// Throughput: one item per cycle while the output is not stalled; the back end
// compares all entries in parallel and shifts the table by one place in the same cycle.
// Reset: entry count and command queue cleared; table contents undefined until written.
module sorted_list_table_core #(
  parameter int DEPTH   = slt_pkg::DEPTH_DEF,
  parameter int VALUE_W = slt_pkg::VALUE_W_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [slt_pkg::S_TDATA_W-1:0]   s_tdata,  // value[31:0], position[35:32], pad
  input  logic [slt_pkg::ACTION_W-1:0]    s_tuser,  // action[1:0]
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [slt_pkg::M_TDATA_W-1:0]   m_tdata,  // entry_value[31:0], entry_count[36:32], pad
  output logic [slt_pkg::STATUS_W-1:0]    m_tuser   // status[1:0]
);
  import slt_pkg::*;

  logic  item_valid;
  logic  item_ready;
  item_t item;

  slt_front u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item)
  );

  slt_back #(
    .DEPTH   (DEPTH),
    .VALUE_W (VALUE_W)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser)
  );

  // a command taken by the back end shows up as a result beat next cycle
  a_exec_to_result: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> m_tvalid)
    else $error("executed command produced no result beat");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == ST_FULL |->
      m_tdata[OUT_VALUE_W+OUT_COUNT_W-1:OUT_VALUE_W] == OUT_COUNT_W'(DEPTH))
    else $error("full status with count short of depth");

  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == ST_EMPTY |->
      m_tdata[OUT_VALUE_W+OUT_COUNT_W-1:OUT_VALUE_W] == '0 && m_tdata[OUT_VALUE_W-1:0] == '0)
    else $error("empty status with nonzero count or value");

endmodule

FILE: rtl/slt_front.sv
// Front end: accepts input beats, decodes the action and queues commands.
module slt_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [slt_pkg::S_TDATA_W-1:0]   s_tdata,  // value[31:0], position[35:32], pad
  input  logic [slt_pkg::ACTION_W-1:0]    s_tuser,  // action[1:0]
  output logic                            item_valid,
  input  logic                            item_ready,
  output slt_pkg::item_t                  item
);
  import slt_pkg::*;

  item_t           mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   level;
  item_t           dec;
  logic            push;
  logic            pop;

  always_comb begin
    dec.value    = s_tdata[IN_VALUE_W-1:0];
    dec.position = s_tdata[IN_VALUE_W+POS_W-1:IN_VALUE_W];
    case (s_tuser)
      ACT_INSERT: dec.op = OP_INSERT;
      ACT_DELETE: dec.op = OP_DELETE;
      ACT_GET:    dec.op = OP_GET;
      default:    dec.op = OP_NOP;
    endcase
  end

  assign s_tready   = (level != (QPTR_W+1)'(QDEPTH));
  assign item_valid = (level != '0);
  assign item       = mem[rd_ptr];
  assign push       = s_tvalid && s_tready;
  assign pop        = item_valid && item_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= dec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   level <= level + 1'b1;
        2'b01:   level <= level - 1'b1;
        default: level <= level;
      endcase
    end
  end

endmodule

FILE: rtl/slt_back.sv
// Back end: sorted shift table, executes one command per unstalled cycle into a result register.
module slt_back #(
  parameter int DEPTH   = slt_pkg::DEPTH_DEF,
  parameter int VALUE_W = slt_pkg::VALUE_W_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            item_valid,
  output logic                            item_ready,
  input  slt_pkg::item_t                  item,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [slt_pkg::M_TDATA_W-1:0]   m_tdata,  // entry_value[31:0], entry_count[36:32], pad
  output logic [slt_pkg::STATUS_W-1:0]    m_tuser   // status[1:0]
);
  import slt_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  logic signed [VALUE_W-1:0] entries  [DEPTH];
  logic signed [VALUE_W-1:0] ins_next [DEPTH];
  logic signed [VALUE_W-1:0] del_next [DEPTH];
  logic [DEPTH-1:0]          lt;
  logic [CNT_W-1:0]          count;
  logic [CNT_W-1:0]          count_next;

  logic                      fire;
  logic                      full;
  logic                      in_range;
  logic                      do_ins;
  logic                      do_del;
  logic signed [63:0]        val64;
  logic signed [VALUE_W-1:0] val_w;
  logic [CMP_W-1:0]          pos_c;
  logic [CMP_W-1:0]          cnt_c;
  logic signed [VALUE_W-1:0] rd;
  logic signed [63:0]        rd64;
  logic [STATUS_W-1:0]       status_c;
  logic [OUT_VALUE_W-1:0]    value_c;

  logic [STATUS_W-1:0]       out_status;
  logic [OUT_VALUE_W-1:0]    out_value;
  logic [OUT_COUNT_W-1:0]    out_count;

  assign item_ready = !m_tvalid || m_tready;
  assign fire       = item_valid && item_ready;

  assign val64    = 64'(signed'(item.value));
  assign val_w    = val64[VALUE_W-1:0];
  assign pos_c    = CMP_W'(item.position);
  assign cnt_c    = CMP_W'(count);
  assign full     = (count == CNT_W'(DEPTH));
  assign in_range = (count != '0) && (pos_c < cnt_c);
  assign rd       = entries[pos_c[IDX_W-1:0]];
  assign rd64     = 64'(rd);
  assign do_ins   = (item.op == OP_INSERT) && !full;
  assign do_del   = (item.op == OP_DELETE) && in_range;

  // lt is a prefix mask over the live entries since the table is sorted
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      lt[i] = (CNT_W'(i) < count) && (entries[i] < val_w);
    end
    ins_next[0] = lt[0] ? entries[0] : val_w;
    for (int i = 1; i < DEPTH; i++) begin
      if (lt[i]) begin
        ins_next[i] = entries[i];
      end else if (lt[i-1]) begin
        ins_next[i] = val_w;
      end else begin
        ins_next[i] = entries[i-1];
      end
    end
    for (int i = 0; i < DEPTH - 1; i++) begin
      if (CMP_W'(i) < pos_c) begin
        del_next[i] = entries[i];
      end else begin
        del_next[i] = entries[i+1];
      end
    end
    del_next[DEPTH-1] = entries[DEPTH-1];
  end

  always_comb begin
    status_c   = ST_OK;
    value_c    = '0;
    count_next = count;
    case (item.op)
      OP_INSERT: begin
        if (full) begin
          status_c = ST_FULL;
        end else begin
          count_next = count + 1'b1;
        end
      end
      OP_DELETE, OP_GET: begin
        if (count == '0) begin
          status_c = ST_EMPTY;
        end else if (!in_range) begin
          status_c = ST_BADPOS;
        end else begin
          value_c = rd64[OUT_VALUE_W-1:0];
          if (item.op == OP_DELETE) count_next = count - 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (fire && do_ins) begin
      entries <= ins_next;
    end else if (fire && do_del) begin
      entries <= del_next;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_status <= status_c;
      out_value  <= value_c;
      out_count  <= OUT_COUNT_W'(count_next);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (fire) begin
        count    <= count_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  assign m_tdata = {(M_TDATA_W - OUT_VALUE_W - OUT_COUNT_W)'(0), out_count, out_value};
  assign m_tuser = out_status;

endmodule

FILE: test/sorted_list_table_core_tb.sv
// Self-checking testbench for sorted_list_table_core: stream driver, shadow list and checker.
module sorted_list_table_core_tb;
  import slt_pkg::*;

  localparam int DEPTH = DEPTH_DEF;
  localparam int RANDOM_ITEMS = 1900;
  localparam int LONG_HOLD = 90;
  localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

  typedef struct {
    logic [ACTION_W-1:0]   action;
    logic [IN_VALUE_W-1:0] value;
    logic [POS_W-1:0]      position;
    int                    gap;
    bit                    drain;
  } list_cmd_t;

  typedef struct {
    logic [STATUS_W-1:0]    status;
    logic [OUT_VALUE_W-1:0] entry_value;
    logic [OUT_COUNT_W-1:0] entry_count;
  } list_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;
  logic [ACTION_W-1:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;
  logic [STATUS_W-1:0] m_tuser;

  sorted_list_table_core DUT (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser)
  );

  always #10 clk = ~clk;

  // shadow copy of the table contents
  logic [OUT_VALUE_W-1:0] list_words [0:DEPTH-1];
  int list_count = 0;

  list_cmd_t send_q[$];
  list_result_t due_results[$];

  logic s_took = 1'b0;
  logic m_took = 1'b0;
  int send_gap = 0;
  int rx_wait = 0;
  int rx_style = 0;
  int gap_style = 1;
  int plan_count = 0;
  int items_queued = 0;
  int results_seen = 0;
  int fail_count = 0;
  int action_seen [0:3];
  int status_seen [0:3];
  list_cmd_t next_cmd;
  list_cmd_t taken_cmd;
  list_result_t want;

  function automatic int draw_wait(input int style);
    case (style)
      0: return 0;
      1: return $urandom_range(0, 18);
      default: return ($urandom_range(0, 7) == 0) ? $urandom_range(0, 18) : 0;
    endcase
  endfunction

  // applies one action to the shadow list and returns the result it gives
  function automatic list_result_t list_apply(input list_cmd_t cmd);
    list_result_t r;
    int at;
    int i;
    r.status = ST_OK;
    r.entry_value = '0;
    case (cmd.action)
      ACT_INSERT: begin
        if (list_count >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          at = 0;
          while (at < list_count && $signed(list_words[at]) < $signed(cmd.value)) at++;
          for (i = list_count; i > at; i--) list_words[i] = list_words[i-1];
          list_words[at] = cmd.value;
          list_count++;
        end
      end
      ACT_DELETE, ACT_GET: begin
        if (list_count == 0) begin
          r.status = ST_EMPTY;
        end else if (int'(cmd.position) >= list_count) begin
          r.status = ST_BADPOS;
        end else begin
          r.entry_value = list_words[cmd.position];
          if (cmd.action == ACT_DELETE) begin
            for (i = int'(cmd.position); i + 1 < list_count; i++) list_words[i] = list_words[i+1];
            list_count--;
          end
        end
      end
      default: ;
    endcase
    r.entry_count = list_count[OUT_COUNT_W-1:0];
    return r;
  endfunction

  // queues one item; plan_count follows the entry count so positions can aim at live entries
  task automatic queue_item(input logic [ACTION_W-1:0] action, input logic [31:0] value,
                            input logic [POS_W-1:0] position);
    list_cmd_t c;
    c.action = action;
    c.value = value;
    c.position = position;
    c.gap = draw_wait(gap_style);
    c.drain = 1'b0;
    send_q.push_back(c);
    items_queued++;
    if (action == ACT_INSERT && plan_count < DEPTH) plan_count++;
    if (action == ACT_DELETE && int'(position) < plan_count) plan_count--;
  endtask

  task automatic queue_drain();
    list_cmd_t c;
    c = '{default: '0};
    c.drain = 1'b1;
    send_q.push_back(c);
  endtask

  // driver
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (s_tvalid && !s_took) begin
      // beat still waiting for ready
    end else begin
      if (s_took) send_gap = (send_q.size() != 0) ? send_q[0].gap : 0;
      if (send_gap > 0) begin
        send_gap--;
        s_tvalid <= 1'b0;
      end else if (send_q.size() == 0) begin
        s_tvalid <= 1'b0;
      end else if (send_q[0].drain) begin
        s_tvalid <= 1'b0;
        if (due_results.size() == 0) send_q.delete(0);
      end else begin
        next_cmd = send_q.pop_front();
        s_tvalid <= 1'b1;
        s_tdata <= {4'b0, next_cmd.position, next_cmd.value};
        s_tuser <= next_cmd.action;
      end
    end
  end

  // receiver ready, with a long hold-off twice in the run
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_took) begin
        if (results_seen % 128 == 0) rx_style = $urandom_range(0, 2);
        rx_wait = draw_wait(rx_style);
        if (results_seen == 300 || results_seen == 1200) rx_wait = LONG_HOLD;
      end
      if (rx_wait > 0) begin
        rx_wait--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // monitor: predict on input beats, check on output beats
  always @(posedge clk) begin
    s_took <= !rst && s_tvalid && s_tready;
    m_took <= !rst && m_tvalid && m_tready;
    if (!rst && s_tvalid && s_tready) begin
      taken_cmd.action = s_tuser;
      taken_cmd.value = s_tdata[31:0];
      taken_cmd.position = s_tdata[35:32];
      action_seen[s_tuser]++;
      due_results.push_back(list_apply(taken_cmd));
    end
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (due_results.size() == 0) begin
        $error("unexpected result beat: status %0d entry_value %0d entry_count %0d",
               m_tuser, $signed(m_tdata[31:0]), m_tdata[36:32]);
        fail_count++;
      end else begin
        want = due_results.pop_front();
        status_seen[want.status]++;
        if (m_tuser !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, m_tuser);
          fail_count++;
        end
        if (m_tdata[31:0] !== want.entry_value) begin
          $error("entry_value: expected %0d, got %0d", $signed(want.entry_value),
                 $signed(m_tdata[31:0]));
          fail_count++;
        end
        if (m_tdata[36:32] !== want.entry_count) begin
          $error("entry_count: expected %0d, got %0d", want.entry_count, m_tdata[36:32]);
          fail_count++;
        end
      end
    end
  end

  initial begin
    #8_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin
    int n;
    int roll;
    int mix;
    int vsel;
    logic [ACTION_W-1:0] act;
    logic [31:0] val;
    logic [POS_W-1:0] pos;
    for (n = 0; n < 4; n++) begin
      action_seen[n] = 0;
      status_seen[n] = 0;
    end

    // directed: empty table, unused code, extremes, fill to full, edges of a full table
    queue_item(ACT_GET, 32'h0000_0000, 4'd0);
    queue_item(ACT_DELETE, 32'hFFFF_FFFF, 4'd15);
    queue_item(ACT_UNUSED, 32'h1234_5678, 4'd9);
    queue_item(ACT_INSERT, 32'h7FFF_FFFF, 4'd0);
    queue_item(ACT_INSERT, 32'h8000_0000, 4'd15);
    queue_item(ACT_INSERT, 32'h0000_0000, 4'd0);
    queue_item(ACT_INSERT, 32'h0000_0000, 4'd0);
    queue_item(ACT_INSERT, 32'hFFFF_FFFF, 4'd0);
    queue_item(ACT_INSERT, 32'h0000_0001, 4'd0);
    for (n = 0; n < 10; n++) queue_item(ACT_INSERT, $urandom_range(0, 16) - 8, 4'd0);
    queue_item(ACT_INSERT, 32'h5A5A_5A5A, 4'd0);
    queue_item(ACT_GET, 32'h0, 4'd15);
    queue_item(ACT_DELETE, 32'h0, 4'd15);
    queue_item(ACT_GET, 32'h0, 4'd15);
    queue_item(ACT_DELETE, 32'h0, 4'd0);
    queue_item(ACT_GET, 32'h0, 4'd0);

    // random: segments lean toward filling, draining or reading the table
    mix = 0;
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 96 == 0) begin
        mix = $urandom_range(0, 3);
        gap_style = $urandom_range(0, 2);
      end
      if (n == 600 || n == 1500) queue_drain();
      roll = $urandom_range(0, 99);
      case (mix)
        0: act = (roll < 65) ? ACT_INSERT : (roll < 80) ? ACT_DELETE : (roll < 98) ? ACT_GET
                                                                                  : ACT_UNUSED;
        1: act = (roll < 20) ? ACT_INSERT : (roll < 80) ? ACT_DELETE : (roll < 98) ? ACT_GET
                                                                                  : ACT_UNUSED;
        2: act = (roll < 40) ? ACT_INSERT : (roll < 70) ? ACT_DELETE : (roll < 98) ? ACT_GET
                                                                                  : ACT_UNUSED;
        default: act = (roll < 50) ? ACT_INSERT : (roll < 60) ? ACT_DELETE
                     : (roll < 98) ? ACT_GET : ACT_UNUSED;
      endcase
      vsel = $urandom_range(0, 9);
      if (act != ACT_INSERT || vsel inside {[4:7]}) val = $urandom;
      else if (vsel == 8) val = 32'h7FFF_FFFF;
      else if (vsel == 9) val = 32'h8000_0000;
      else val = $urandom_range(0, 16) - 8;
      if (plan_count > 0 && $urandom_range(0, 9) != 0) begin
        pos = POS_W'($urandom_range(0, plan_count - 1));
      end else begin
        pos = POS_W'($urandom_range(0, 15));
      end
      queue_item(act, val, pos);
    end

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    // wait on the checked count so the last beat cannot slip past the exit test
    while (results_seen < items_queued) @(negedge clk);
    repeat (8) @(posedge clk);
    $display("Covered %0d inserts, %0d deletes, %0d gets, %0d unused codes; %0d results checked",
             action_seen[ACT_INSERT], action_seen[ACT_DELETE], action_seen[ACT_GET],
             action_seen[ACT_UNUSED], results_seen);
    $display("Status mix: ok %0d, empty %0d, bad position %0d, full %0d; %0d mismatches",
             status_seen[ST_OK], status_seen[ST_EMPTY], status_seen[ST_BADPOS],
             status_seen[ST_FULL], fail_count);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
